@@ rtl/pfl_pkg.sv @@
`timescale 1ns / 1ps
// pfl_pkg: shared widths, types, register indexes and helpers for fragment lighting
package pfl_pkg;

   localparam int VEC_W = 34;
   localparam int MAG_W = 34;
   localparam int UBITS = 30;
   localparam int M_W = 30;
   localparam int SQ_W = 62;
   localparam int ROOT_W = 31;
   localparam int UNIT_W = 32;
   localparam int FRAC_W = 31;
   localparam int SHIN_W = 7;
   localparam int POW_STAGES = 127;
   localparam int COLOR_FRAC_BITS = 15;
   localparam int COLOR_W = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int POS_W = 32;
   localparam int NRM_W = 16;
   localparam int DOT_W = 64;

   localparam logic [SHIN_W-1:0] SHIN_RESET = 7'd40;
   localparam logic [FRAC_W-1:0] FRAC_ONE = 31'h4000_0000;
   localparam logic signed [DOT_W-1:0] DOT_ONE = 64'sh1000_0000_0000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAMERA_X,
      CSR_CAMERA_Y,
      CSR_CAMERA_Z,
      CSR_LIGHT_X,
      CSR_LIGHT_Y,
      CSR_LIGHT_Z,
      CSR_SHININESS
   } csr_index_type;

   typedef logic signed [UNIT_W-1:0] unit_type;
   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic [FRAC_W-1:0] frac_type;

   typedef struct packed {
      frac_type d;
      frac_type dt;
      unit_type lx;
      unit_type ly;
      unit_type lz;
   } side_type;

   // clamp a dot product with 60 fraction bits to [0,1], 30 fraction bits out
   function automatic frac_type clamp01(input logic signed [DOT_W-1:0] dsum);
      if (dsum <= 64'sd0) begin
         return '0;
      end else if (dsum > DOT_ONE) begin
         return FRAC_ONE;
      end else begin
         return dsum[2*UBITS:UBITS];
      end
   endfunction

endpackage

@@ rtl/phong_fragment_lighting.sv @@
`timescale 1ns / 1ps
// phong_fragment_lighting: top level of the pipelined phong fragment shader
//
// req_ carries one fragment per word: world position and interpolated normal.
// rsp_ returns one word per fragment with red, green and blue, in order.
// csr_ writes camera position, light position and shininess; write them only
// while no fragment is in flight.
// The pipeline takes one word per cycle while it is not held. Its path holds
// two normalizers in series of 68 stages each (31 square-root and 31 division
// stages), a 127-stage power chain with one multiply per stage, plus
// dot-product, reflection and output stages.
// When rsp_tready is low with a word waiting, the whole pipeline holds and
// req_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and sets camera and light to zero and the
// shininess to 40.
module phong_fragment_lighting (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z
   input  logic [143:0]                       req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // red, green, blue
   output logic [47:0]                        rsp_tdata,
   input  logic                               csr_wr_en,
   input  logic [pfl_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [pfl_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import pfl_pkg::*;

   function automatic logic [COLOR_W-1:0] to_color(input logic [31:0] v);
      logic [31:0] q;
      q = v >> (UBITS - COLOR_FRAC_BITS);
      if (q > 32'(16'hFFFF)) begin
         return 16'hFFFF;
      end else begin
         return q[COLOR_W-1:0];
      end
   endfunction

   // configuration registers
   logic signed [POS_W-1:0] cam_ff [3];
   logic signed [POS_W-1:0] light_ff [3];
   logic [SHIN_W-1:0]       shin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cam_ff[i]   <= '0;
            light_ff[i] <= '0;
         end
         shin_ff <= SHIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CAMERA_X:  cam_ff[0]   <= csr_wdata;
            CSR_CAMERA_Y:  cam_ff[1]   <= csr_wdata;
            CSR_CAMERA_Z:  cam_ff[2]   <= csr_wdata;
            CSR_LIGHT_X:   light_ff[0] <= csr_wdata;
            CSR_LIGHT_Y:   light_ff[1] <= csr_wdata;
            CSR_LIGHT_Z:   light_ff[2] <= csr_wdata;
            CSR_SHININESS: shin_ff     <= csr_wdata[SHIN_W-1:0];
            default: ;
         endcase
      end
   end

   logic en;
   logic rsp_tvalid_ff;
   logic [47:0] rsp_tdata_ff;

   assign en = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // input stage: light and view vectors
   logic signed [POS_W-1:0] pos [3];
   logic signed [NRM_W-1:0] nrm [3];
   logic    s0_valid_ff;
   vec_type s0_l_ff [3];
   vec_type s0_v_ff [3];
   vec_type s0_n_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pos[i] = req_tdata[POS_W*i +: POS_W];
         nrm[i] = req_tdata[3*POS_W + NRM_W*i +: NRM_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_tvalid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s0_l_ff[i] <= VEC_W'(light_ff[i]) - VEC_W'(pos[i]);
            s0_v_ff[i] <= VEC_W'(cam_ff[i]) - VEC_W'(pos[i]);
            s0_n_ff[i] <= VEC_W'(nrm[i]);
         end
      end
   end

   unit_type l_vec [3];
   unit_type n_vec [3];
   unit_type v_vec [3];
   logic     u_valid;

   pfl_unit u_unit_l (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_l_ff),
      .in_side   ('0),
      .out_valid (u_valid),
      .out_vec   (l_vec),
      .out_side  ()
   );

   pfl_unit u_unit_n (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_n_ff),
      .in_side   ('0),
      .out_valid (),
      .out_vec   (n_vec),
      .out_side  ()
   );

   pfl_unit u_unit_v (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s0_valid_ff),
      .in_vec    (s0_v_ff),
      .in_side   ('0),
      .out_valid (),
      .out_vec   (v_vec),
      .out_side  ()
   );

   // products for N.L, N.I and ny^2
   logic                    p1_valid_ff;
   logic signed [DOT_W-1:0] p1_nl_ff [3];
   logic signed [DOT_W-1:0] p1_ni_ff [3];
   logic signed [DOT_W-1:0] p1_nyy_ff;
   logic signed [UNIT_W:0]  p1_i_in [3];
   logic signed [UNIT_W:0]  p1_i_ff [3];
   unit_type                p1_l_ff [3];
   unit_type                p1_n_ff [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_i_in[i] = -((UNIT_W+1)'(v_vec[i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (en) begin
         p1_valid_ff <= u_valid;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p1_nl_ff[i] <= DOT_W'(n_vec[i]) * DOT_W'(l_vec[i]);
            p1_ni_ff[i] <= DOT_W'(n_vec[i]) * DOT_W'(p1_i_in[i]);
         end
         p1_nyy_ff <= DOT_W'(n_vec[1]) * DOT_W'(n_vec[1]);
         p1_i_ff   <= p1_i_in;
         p1_l_ff   <= l_vec;
         p1_n_ff   <= n_vec;
      end
   end

   // diffuse, blend factor and N.I
   logic                    p2_valid_ff;
   frac_type                p2_d_ff;
   frac_type                p2_t_ff;
   logic signed [DOT_W-1:0] p2_nl_sum;
   logic signed [DOT_W-1:0] p2_ni_sum;
   logic signed [VEC_W-1:0] p2_ndi_ff;
   logic signed [UNIT_W:0]  p2_i_ff [3];
   unit_type                p2_l_ff [3];
   unit_type                p2_n_ff [3];

   assign p2_nl_sum = p1_nl_ff[0] + p1_nl_ff[1] + p1_nl_ff[2];
   assign p2_ni_sum = p1_ni_ff[0] + p1_ni_ff[1] + p1_ni_ff[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else if (en) begin
         p2_valid_ff <= p1_valid_ff;
      end
      if (en) begin
         p2_d_ff   <= clamp01(p2_nl_sum);
         p2_t_ff   <= (p1_n_ff[1] > 0) ? p1_nyy_ff[2*UBITS:UBITS] : '0;
         p2_ndi_ff <= p2_ni_sum[DOT_W-1:UBITS];
         p2_i_ff   <= p1_i_ff;
         p2_l_ff   <= p1_l_ff;
         p2_n_ff   <= p1_n_ff;
      end
   end

   // reflection products and d*t
   localparam int RP_W = VEC_W + UNIT_W;
   logic                   p3_valid_ff;
   logic signed [RP_W-1:0] p3_rp_ff [3];
   logic [2*FRAC_W-1:0]    p3_dtp_ff;
   frac_type               p3_d_ff;
   logic signed [UNIT_W:0] p3_i_ff [3];
   unit_type               p3_l_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
      end else if (en) begin
         p3_valid_ff <= p2_valid_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            p3_rp_ff[i] <= RP_W'(p2_ndi_ff) * RP_W'(p2_n_ff[i]);
         end
         p3_dtp_ff <= (2*FRAC_W)'(p2_d_ff) * (2*FRAC_W)'(p2_t_ff);
         p3_d_ff   <= p2_d_ff;
         p3_i_ff   <= p2_i_ff;
         p3_l_ff   <= p2_l_ff;
      end
   end

   // reflected vector
   logic                     p4_valid_ff;
   logic signed [RP_W+1:0]   p4_fl [3];
   vec_type                  p4_rv_in [3];
   vec_type                  p4_rv_ff [3];
   side_type                 p4_side_in;
   side_type                 p4_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p4_fl[i]    = (RP_W+2)'(p3_rp_ff[i] >>> UBITS);
         p4_rv_in[i] = VEC_W'((RP_W+2)'(p3_i_ff[i]) - (p4_fl[i] <<< 1));
      end
      p4_side_in.d  = p3_d_ff;
      p4_side_in.dt = p3_dtp_ff[2*UBITS:UBITS];
      p4_side_in.lx = p3_l_ff[0];
      p4_side_in.ly = p3_l_ff[1];
      p4_side_in.lz = p3_l_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p4_valid_ff <= 1'b0;
      end else if (en) begin
         p4_valid_ff <= p3_valid_ff;
      end
      if (en) begin
         p4_rv_ff   <= p4_rv_in;
         p4_side_ff <= p4_side_in;
      end
   end

   unit_type r_vec [3];
   side_type r_side;
   logic     r_valid;

   pfl_unit u_unit_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p4_valid_ff),
      .in_vec    (p4_rv_ff),
      .in_side   (p4_side_ff),
      .out_valid (r_valid),
      .out_vec   (r_vec),
      .out_side  (r_side)
   );

   // R.L
   logic                    q1_valid_ff;
   logic signed [DOT_W-1:0] q1_rl_ff [3];
   frac_type                q1_d_ff;
   frac_type                q1_dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff <= 1'b0;
      end else if (en) begin
         q1_valid_ff <= r_valid;
      end
      if (en) begin
         q1_rl_ff[0] <= DOT_W'(r_vec[0]) * DOT_W'(r_side.lx);
         q1_rl_ff[1] <= DOT_W'(r_vec[1]) * DOT_W'(r_side.ly);
         q1_rl_ff[2] <= DOT_W'(r_vec[2]) * DOT_W'(r_side.lz);
         q1_d_ff     <= r_side.d;
         q1_dt_ff    <= r_side.dt;
      end
   end

   logic     q2_valid_ff;
   frac_type q2_s_ff;
   frac_type q2_d_ff;
   frac_type q2_dt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q2_valid_ff <= 1'b0;
      end else if (en) begin
         q2_valid_ff <= q1_valid_ff;
      end
      if (en) begin
         q2_s_ff  <= clamp01(q1_rl_ff[0] + q1_rl_ff[1] + q1_rl_ff[2]);
         q2_d_ff  <= q1_d_ff;
         q2_dt_ff <= q1_dt_ff;
      end
   end

   logic     pw_valid;
   frac_type pw_val;
   frac_type pw_d;
   frac_type pw_dt;

   pfl_pow u_pow (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q2_valid_ff),
      .in_s      (q2_s_ff),
      .in_d      (q2_d_ff),
      .in_dt     (q2_dt_ff),
      .shin      (shin_ff),
      .out_valid (pw_valid),
      .out_pw    (pw_val),
      .out_d     (pw_d),
      .out_dt    (pw_dt)
   );

   // output word
   logic [31:0]        spec;
   logic [COLOR_W-1:0] rb_in;
   logic [COLOR_W-1:0] g_in;

   assign spec  = 32'(pw_val >> 1);
   assign rb_in = to_color(32'(pw_dt) + spec);
   assign g_in  = to_color(32'(pw_d) + spec);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= pw_valid;
      end
      if (en) begin
         rsp_tdata_ff <= {rb_in, g_in, rb_in};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_red_blue: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] == rsp_tdata[47:32])
      else $error("red and blue differ");

   a_green_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[31:16] <= 16'd49152)
      else $error("green above 1.5");

   a_red_le_green: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:0] <= rsp_tdata[31:16])
      else $error("red above green");

endmodule

@@ rtl/pfl_unit.sv @@
`timescale 1ns / 1ps
// pfl_unit: pipelined vector normalizer (scale, square root, long division)
module pfl_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  pfl_pkg::vec_type   in_vec [3],
   input  pfl_pkg::side_type  in_side,
   output logic               out_valid,
   output pfl_pkg::unit_type  out_vec [3],
   output pfl_pkg::side_type  out_side
);
   import pfl_pkg::*;

   localparam int RT_N = ROOT_W;
   localparam int DV_W = ROOT_W + 1;

   // magnitudes and largest one
   logic             s1_valid_ff;
   logic [MAG_W-1:0] s1_mag_ff [3];
   logic [MAG_W-1:0] s1_mag_in [3];
   logic [MAG_W-1:0] s1_mx_ff;
   logic [MAG_W-1:0] s1_mx_in;
   logic [2:0]       s1_neg_ff;
   side_type         s1_side_ff;

   always_comb begin
      s1_mx_in = '0;
      for (int i = 0; i < 3; i++) begin
         s1_mag_in[i] = in_vec[i][VEC_W-1] ? MAG_W'(-in_vec[i]) : MAG_W'(in_vec[i]);
         if (s1_mag_in[i] > s1_mx_in) begin
            s1_mx_in = s1_mag_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
      end
      if (en) begin
         s1_mag_ff  <= s1_mag_in;
         s1_mx_ff   <= s1_mx_in;
         s1_side_ff <= in_side;
         for (int i = 0; i < 3; i++) begin
            s1_neg_ff[i] <= in_vec[i][VEC_W-1];
         end
      end
   end

   // scale so the largest magnitude lies in [2^29, 2^30)
   logic           s2_valid_ff;
   logic [5:0]     s2_msb;
   logic [M_W-1:0] s2_m_in [3];
   logic [M_W-1:0] s2_m_ff [3];
   logic [2:0]     s2_neg_ff;
   logic           s2_zero_ff;
   side_type       s2_side_ff;

   always_comb begin
      s2_msb = '0;
      for (int b = 0; b < MAG_W; b++) begin
         if (s1_mx_ff[b]) begin
            s2_msb = 6'(b);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (s2_msb >= 6'(M_W - 1)) begin
            s2_m_in[i] = M_W'(s1_mag_ff[i] >> (s2_msb - 6'(M_W - 1)));
         end else begin
            s2_m_in[i] = M_W'(s1_mag_ff[i] << (6'(M_W - 1) - s2_msb));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (en) begin
         s2_m_ff    <= s2_m_in;
         s2_neg_ff  <= s1_neg_ff;
         s2_zero_ff <= (s1_mx_ff == '0);
         s2_side_ff <= s1_side_ff;
      end
   end

   // squares
   logic             s3_valid_ff;
   logic [2*M_W-1:0] s3_sq_ff [3];
   logic [M_W-1:0]   s3_m_ff [3];
   logic [2:0]       s3_neg_ff;
   logic             s3_zero_ff;
   side_type         s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            s3_sq_ff[i] <= (2*M_W)'(s2_m_ff[i]) * (2*M_W)'(s2_m_ff[i]);
         end
         s3_m_ff    <= s2_m_ff;
         s3_neg_ff  <= s2_neg_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // square root, one result bit per stage
   logic              rt_valid_ff [0:RT_N];
   logic [SQ_W-1:0]   rt_rem_ff   [0:RT_N];
   logic [ROOT_W-1:0] rt_root_ff  [0:RT_N];
   logic [M_W-1:0]    rt_m_ff     [0:RT_N][3];
   logic [2:0]        rt_neg_ff   [0:RT_N];
   logic              rt_zero_ff  [0:RT_N];
   side_type          rt_side_ff  [0:RT_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_valid_ff[0] <= 1'b0;
      end else if (en) begin
         rt_valid_ff[0] <= s3_valid_ff;
      end
      if (en) begin
         rt_rem_ff[0]  <= SQ_W'(s3_sq_ff[0]) + SQ_W'(s3_sq_ff[1]) + SQ_W'(s3_sq_ff[2]);
         rt_root_ff[0] <= '0;
         rt_m_ff[0]    <= s3_m_ff;
         rt_neg_ff[0]  <= s3_neg_ff;
         rt_zero_ff[0] <= s3_zero_ff;
         rt_side_ff[0] <= s3_side_ff;
      end
   end

   for (genvar j = 0; j < RT_N; j++) begin : g_root
      localparam int B = RT_N - 1 - j;
      logic [63:0] trial;
      logic        take;

      assign trial = (64'(rt_root_ff[j]) << (B + 1)) | (64'd1 << (2 * B));
      assign take  = 64'(rt_rem_ff[j]) >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            rt_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            rt_valid_ff[j+1] <= rt_valid_ff[j];
         end
         if (en) begin
            rt_rem_ff[j+1]  <= take ? SQ_W'(64'(rt_rem_ff[j]) - trial) : rt_rem_ff[j];
            rt_root_ff[j+1] <= take ? (rt_root_ff[j] | (ROOT_W'(1) << B)) : rt_root_ff[j];
            rt_m_ff[j+1]    <= rt_m_ff[j];
            rt_neg_ff[j+1]  <= rt_neg_ff[j];
            rt_zero_ff[j+1] <= rt_zero_ff[j];
            rt_side_ff[j+1] <= rt_side_ff[j];
         end
      end
   end

   // division m * 2^30 / len, one quotient bit per stage
   logic              dv_valid_ff [0:RT_N];
   logic [DV_W-1:0]   dv_rem_ff   [0:RT_N][3];
   logic [ROOT_W-1:0] dv_q_ff     [0:RT_N][3];
   logic [ROOT_W-1:0] dv_len_ff   [0:RT_N];
   logic [2:0]        dv_neg_ff   [0:RT_N];
   logic              dv_zero_ff  [0:RT_N];
   side_type          dv_side_ff  [0:RT_N];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff[0] <= 1'b0;
      end else if (en) begin
         dv_valid_ff[0] <= rt_valid_ff[RT_N];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= DV_W'(rt_m_ff[RT_N][i]);
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0]  <= rt_root_ff[RT_N];
         dv_neg_ff[0]  <= rt_neg_ff[RT_N];
         dv_zero_ff[0] <= rt_zero_ff[RT_N];
         dv_side_ff[0] <= rt_side_ff[RT_N];
      end
   end

   for (genvar j = 0; j < RT_N; j++) begin : g_div
      logic [DV_W-1:0] cand [3];
      logic [2:0]      take;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (j == 0) begin
               cand[i] = dv_rem_ff[j][i];
            end else begin
               cand[i] = dv_rem_ff[j][i] << 1;
            end
            take[i] = cand[i] >= DV_W'(dv_len_ff[j]);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j+1] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[j+1] <= dv_valid_ff[j];
         end
         if (en) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[j+1][i] <= take[i] ? cand[i] - DV_W'(dv_len_ff[j]) : cand[i];
               dv_q_ff[j+1][i]   <= {dv_q_ff[j][i][ROOT_W-2:0], take[i]};
            end
            dv_len_ff[j+1]  <= dv_len_ff[j];
            dv_neg_ff[j+1]  <= dv_neg_ff[j];
            dv_zero_ff[j+1] <= dv_zero_ff[j];
            dv_side_ff[j+1] <= dv_side_ff[j];
         end
      end
   end

   // sign back
   logic     out_valid_ff;
   unit_type out_vec_ff [3];
   unit_type out_q_in [3];
   side_type out_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_q_in[i] = signed'(UNIT_W'(dv_q_ff[RT_N][i]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid_ff[RT_N];
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dv_zero_ff[RT_N]) begin
               out_vec_ff[i] <= '0;
            end else if (dv_neg_ff[RT_N][i]) begin
               out_vec_ff[i] <= -out_q_in[i];
            end else begin
               out_vec_ff[i] <= out_q_in[i];
            end
         end
         out_side_ff <= dv_side_ff[RT_N];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_vec   = out_vec_ff;
   assign out_side  = out_side_ff;

endmodule

@@ rtl/pfl_pow.sv @@
`timescale 1ns / 1ps
// pfl_pow: specular power chain, one truncated multiply per stage
module pfl_pow (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  pfl_pkg::frac_type             in_s,
   input  pfl_pkg::frac_type             in_d,
   input  pfl_pkg::frac_type             in_dt,
   input  logic [pfl_pkg::SHIN_W-1:0]    shin,
   output logic                          out_valid,
   output pfl_pkg::frac_type             out_pw,
   output pfl_pkg::frac_type             out_d,
   output pfl_pkg::frac_type             out_dt
);
   import pfl_pkg::*;

   logic     pw_valid_ff [0:POW_STAGES-1];
   frac_type pw_ff       [0:POW_STAGES-1];
   frac_type pw_s_ff     [0:POW_STAGES-1];
   frac_type pw_d_ff     [0:POW_STAGES-1];
   frac_type pw_dt_ff    [0:POW_STAGES-1];

   for (genvar e = 0; e < POW_STAGES; e++) begin : g_stage
      logic                  src_valid;
      frac_type              src_pw;
      frac_type              src_s;
      frac_type              src_d;
      frac_type              src_dt;
      logic [2*FRAC_W-1:0]   prod;

      if (e == 0) begin : g_head
         assign src_valid = in_valid;
         assign src_pw    = FRAC_ONE;
         assign src_s     = in_s;
         assign src_d     = in_d;
         assign src_dt    = in_dt;
      end else begin : g_body
         assign src_valid = pw_valid_ff[e-1];
         assign src_pw    = pw_ff[e-1];
         assign src_s     = pw_s_ff[e-1];
         assign src_d     = pw_d_ff[e-1];
         assign src_dt    = pw_dt_ff[e-1];
      end

      assign prod = (2*FRAC_W)'(src_pw) * (2*FRAC_W)'(src_s);

      always_ff @(posedge clock) begin
         if (reset) begin
            pw_valid_ff[e] <= 1'b0;
         end else if (en) begin
            pw_valid_ff[e] <= src_valid;
         end
         if (en) begin
            pw_ff[e]    <= (SHIN_W'(e) < shin) ? prod[UBITS+FRAC_W-1:UBITS] : src_pw;
            pw_s_ff[e]  <= src_s;
            pw_d_ff[e]  <= src_d;
            pw_dt_ff[e] <= src_dt;
         end
      end
   end

   assign out_valid = pw_valid_ff[POW_STAGES-1];
   assign out_pw    = pw_ff[POW_STAGES-1];
   assign out_d     = pw_d_ff[POW_STAGES-1];
   assign out_dt    = pw_dt_ff[POW_STAGES-1];

endmodule

@@ sim/phong_fragment_lighting_test.sv @@
`timescale 1ns / 1ps
// phong_fragment_lighting_test: self-checking testbench for the phong fragment lighting pipeline
module phong_fragment_lighting_test;
   import pfl_pkg::*;

   typedef longint triple_type [3];

   localparam int LATENCY = 271;
   localparam longint CYCLE_LIMIT = 600000;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam longint ONE_Q30 = 64'd1 << 30;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   longint cam_pos [3];
   longint light_pos [3];
   int shin_exp;
   int send_idle_pct;
   int recv_idle_pct;
   int mismatches;
   longint cycles;
   logic [47:0] pending_colors [$];

   phong_fragment_lighting uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit [63:0] int_sqrt(input bit [63:0] x);
      bit [63:0] res;
      bit [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= res + b) begin
            x = x - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic triple_type normalize(input triple_type v);
      bit [63:0] m [3];
      bit [63:0] mx;
      bit [63:0] sum;
      bit [63:0] len;
      longint q;
      triple_type u;
      mx = 0;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = v[i] < 0 ? -v[i] : v[i];
         if (m[i] > mx) mx = m[i];
      end
      if (mx == 0) begin
         u[0] = 0; u[1] = 0; u[2] = 0;
         return u;
      end
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         mx = mx >> 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         mx = mx << 1;
      end
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = longint'((m[i] << 30) / len);
         u[i] = v[i] < 0 ? -q : q;
      end
      return u;
   endfunction

   function automatic longint dot3(input triple_type a, input triple_type b);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
   endfunction

   function automatic longint clamp_unit(input longint d);
      if (d <= 0) return 0;
      if (d > (ONE_Q30 << 30)) d = ONE_Q30 << 30;
      return d >>> 30;
   endfunction

   function automatic logic [15:0] color_q15(input longint v);
      longint q;
      q = v >>> (30 - COLOR_FRAC_BITS);
      return q > 65535 ? 16'hFFFF : q[15:0];
   endfunction

   function automatic logic [47:0] shade_fragment(input logic [143:0] w);
      triple_type lv, vv, nv, lu, vu, nu, iv, rv, ru;
      longint p, d, s, pw, ny, t, dt, ndi;
      for (int i = 0; i < 3; i++) begin
         p = longint'($signed(w[32*i +: 32]));
         nv[i] = longint'($signed(w[96 + 16*i +: 16]));
         lv[i] = light_pos[i] - p;
         vv[i] = cam_pos[i] - p;
      end
      lu = normalize(lv);
      nu = normalize(nv);
      vu = normalize(vv);
      d = clamp_unit(dot3(nu, lu));
      for (int i = 0; i < 3; i++) iv[i] = -vu[i];
      ndi = dot3(nu, iv) >>> 30;
      for (int i = 0; i < 3; i++) rv[i] = iv[i] - 2 * ((ndi * nu[i]) >>> 30);
      ru = normalize(rv);
      s = clamp_unit(dot3(ru, lu));
      pw = ONE_Q30;
      for (int e = 0; e < shin_exp; e++) pw = (pw * s) >>> 30;
      pw = pw >>> 1;
      ny = nu[1];
      t = ny > 0 ? (ny * ny) >>> 30 : 0;
      dt = (d * t) >>> 30;
      return {color_q15(dt + pw), color_q15(d + pw), color_q15(dt + pw)};
   endfunction

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) pending_colors.push_back(shade_fragment(req_tdata));
   end

   always @(posedge clock) begin
      logic [47:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_colors.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %h", rsp_tdata);
         end else begin
            want = pending_colors.pop_front();
            for (int f = 0; f < 3; f++) begin
               if (rsp_tdata[16*f +: 16] !== want[16*f +: 16]) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("color %0d mismatch: expected %h actual %h", f,
                              want[16*f +: 16], rsp_tdata[16*f +: 16]);
               end
            end
         end
      end
   end

   always @(negedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx < 3) cam_pos[idx] = longint'($signed(val));
      else if (idx < 6) light_pos[idx - 3] = longint'($signed(val));
      else if (idx == CSR_SHININESS) shin_exp = int'(val[6:0]);
   endtask

   task automatic set_scene(input logic [31:0] cx, cy, cz, lx, ly, lz, input logic [31:0] sh);
      write_reg(CSR_CAMERA_X, cx);
      write_reg(CSR_CAMERA_Y, cy);
      write_reg(CSR_CAMERA_Z, cz);
      write_reg(CSR_LIGHT_X, lx);
      write_reg(CSR_LIGHT_Y, ly);
      write_reg(CSR_LIGHT_Z, lz);
      write_reg(CSR_SHININESS, sh);
   endtask

   // called at a falling edge, returns at a falling edge
   task automatic send_fragment(input logic [31:0] px, py, pz, input logic [15:0] nx, ny, nz);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {nz, ny, nx, pz, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_colors.size() != 0) @(posedge clock);
      repeat (LATENCY + 30) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_pos(input int mode);
      case (mode)
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
         default: return 32'($signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000);
      endcase
   endfunction

   task automatic test_directed;
      send_idle_pct = 18;
      recv_idle_pct = 73;
      @(negedge clock);
      // camera and light at origin, fragment at origin: zero light and view vectors
      send_fragment(0, 0, 0, 16'h4000, 16'h0000, 16'h0000);
      send_fragment(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
      send_fragment(32'h0001_0000, 0, 0, 16'h0000, 16'h0000, 16'h0000);
      send_fragment(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_fragment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000, 16'h8000);
      drain();
      set_scene(32'h0000_0000, 32'h0005_0000, 32'h000A_0000,
                32'h0000_0000, 32'h000A_0000, 32'h0000_0000, 1);
      send_fragment(0, 0, 0, 16'h0000, 16'h4000, 16'h0000);
      send_fragment(0, 0, 0, 16'h0000, 16'h7FFF, 16'h0000);
      send_fragment(0, 0, 0, 16'h0000, 16'h8000, 16'h0000);
      send_fragment(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
      send_fragment(0, 0, 0, 16'h0001, 16'h0001, 16'hFFFF);
      drain();
      // shininess zero: power of one
      write_reg(CSR_SHININESS, 0);
      send_fragment(0, 0, 0, 16'h0000, 16'h4000, 16'h0000);
      send_fragment(0, 0, 0, 16'h2000, 16'h2000, 16'h2000);
      drain();
      write_reg(CSR_SHININESS, 127);
      send_fragment(0, 0, 0, 16'h0000, 16'h4000, 16'h0000);
      send_fragment(0, 0, 0, 16'h0000, 16'h4000, 16'h1000);
      drain();
      // unused index leaves every register alone
      write_reg(CSR_UNUSED_INDEX, 32'hFFFF_FFFF);
      set_scene(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FF80 | 7'd64);
      send_fragment(0, 0, 0, 16'h4000, 16'h4000, 16'h4000);
      send_fragment(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h0);
      send_fragment(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h0);
      drain();
   endtask

   task automatic test_random(input int n_items, input int s_idle, input int r_idle,
                              input int cfg_mode);
      int mode;
      logic [31:0] sh;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      sh = (cfg_mode == 0) ? 1 : (cfg_mode == 1) ? 127 : $urandom_range(0, 127);
      set_scene(rand_pos(cfg_mode % 3), rand_pos(cfg_mode % 3), rand_pos(cfg_mode % 3),
                rand_pos(cfg_mode % 3), rand_pos(cfg_mode % 3), rand_pos(cfg_mode % 3), sh);
      for (int k = 0; k < n_items; k++) begin
         mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 2);
         if ($urandom_range(0, 19) == 0) begin
            send_fragment(rand_pos(mode), rand_pos(mode), rand_pos(mode), 0, 0, 0);
         end else begin
            send_fragment(rand_pos(mode), rand_pos(mode), rand_pos(mode),
                          16'($urandom), 16'($urandom), 16'($urandom));
         end
         // stretch with no idling on either side
         if (k == n_items / 2) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
      drain();
   endtask

   initial begin
      mismatches = 0;
      cycles = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 3; i++) begin
         cam_pos[i] = 0;
         light_pos[i] = 0;
      end
      shin_exp = int'(SHIN_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);
      test_directed();
      test_random(400, 18, 73, 0);
      test_random(400, 73, 18, 1);
      test_random(400, 0, 0, 2);
      test_random(400, 18, 73, 3);
      if (mismatches == 0 && pending_colors.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
